// ----- rtl/sts_pkg.sv -----
// Shared types and constants of the sorted table binary search core.
package sts_pkg;

    localparam int unsigned INDEX_W = 10;
    localparam int unsigned BOUND_W = 11;
    localparam int unsigned RANGE_W = 12;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned S_DATA_W = 96;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        logic [VALUE_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
    } rd_req_t;

endpackage

// ----- rtl/sts_table.sv -----
// Table memory with one write port and one registered read port.
module sts_table #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  sts_pkg::wr_req_t              wr_req,
    input  sts_pkg::rd_req_t              rd_req,
    output logic [sts_pkg::VALUE_W-1:0]   rd_data
);
    import sts_pkg::*;

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [31:0]        wr_wide;
    logic [31:0]        rd_wide;
    logic               wr_in_range;

    assign wr_wide     = 32'(wr_req.addr);
    assign rd_wide     = 32'(rd_req.addr);
    assign wr_in_range = (wr_wide < 32'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_req.en && wr_in_range) begin
            mem[wr_wide[ADDR_W-1:0]] <= wr_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_data_reg <= mem[rd_wide[ADDR_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sts_ctrl.sv -----
// Search sequencer with the result output register.
module sts_ctrl #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_op,
    input  logic [sts_pkg::INDEX_W-1:0]   s_write_address,
    input  logic [sts_pkg::VALUE_W-1:0]   s_entry_value,
    input  logic [sts_pkg::INDEX_W-1:0]   s_low_bound,
    input  logic [sts_pkg::BOUND_W-1:0]   s_high_bound,
    input  logic [sts_pkg::VALUE_W-1:0]   s_key,
    output sts_pkg::wr_req_t              wr_req,
    output sts_pkg::rd_req_t              rd_req,
    input  logic [sts_pkg::VALUE_W-1:0]   rd_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_found,
    output logic [sts_pkg::INDEX_W-1:0]   m_position
);
    import sts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [RANGE_W-1:0]  lo_reg, lo_next;
    logic [RANGE_W-1:0]  hi_reg, hi_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [INDEX_W-1:0]  mid_reg, mid_next;
    logic                oob_reg, oob_next;
    logic                res_found_reg, res_found_next;
    logic [INDEX_W-1:0]  res_pos_reg, res_pos_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [INDEX_W-1:0]  m_pos_reg, m_pos_next;

    logic [RANGE_W-1:0]  mid_sum;
    logic [INDEX_W-1:0]  mid_calc;
    logic [VALUE_W-1:0]  entry;
    logic                accept;
    logic                out_load;

    assign mid_sum  = lo_reg + hi_reg;
    assign mid_calc = mid_sum[INDEX_W:1];
    assign entry    = oob_reg ? '0 : rd_data;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign wr_req.en   = accept && (op_t'(s_op) == OP_WRITE);
    assign wr_req.addr = s_write_address;
    assign wr_req.data = s_entry_value;

    assign rd_req.en   = (state_reg == ST_PROBE) && ($signed(lo_reg) <= $signed(hi_reg));
    assign rd_req.addr = mid_calc;

    always_comb begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        mid_next       = mid_reg;
        oob_next       = oob_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (op_t'(s_op) == OP_SEARCH)) begin
                    lo_next    = {{(RANGE_W-INDEX_W){1'b0}}, s_low_bound};
                    hi_next    = {{(RANGE_W-BOUND_W){s_high_bound[BOUND_W-1]}}, s_high_bound};
                    key_next   = s_key;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if ($signed(lo_reg) > $signed(hi_reg)) begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = ST_DONE;
                end else begin
                    mid_next   = mid_calc;
                    oob_next   = ({{(32-INDEX_W){1'b0}}, mid_calc} >= 32'(TABLE_DEPTH));
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (key_reg == entry) begin
                    res_found_next = 1'b1;
                    res_pos_next   = mid_reg;
                    state_next     = ST_DONE;
                end else if ($signed(key_reg) > $signed(entry)) begin
                    lo_next    = {{(RANGE_W-INDEX_W){1'b0}}, mid_reg} + RANGE_W'(1);
                    state_next = ST_PROBE;
                end else begin
                    hi_next    = {{(RANGE_W-INDEX_W){1'b0}}, mid_reg} - RANGE_W'(1);
                    state_next = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_found_next = res_found_reg;
            m_pos_next   = res_pos_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        key_reg       <= key_next;
        mid_reg       <= mid_next;
        oob_reg       <= oob_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_pos_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> $past(state_reg == ST_PROBE))
        else $error("Compare step was not preceded by a probe.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> ($signed(lo_reg) <= $signed(hi_reg)))
        else $error("Compare step entered with an empty range.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_pos_reg == '0))
        else $error("Not-found result carries a nonzero position.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result appeared without a finished search.");

endmodule

// ----- rtl/sorted_table_binary_search_core.sv -----
// Top level of the sorted table binary search core.
//
//  Channel | Direction | Content
//  s_      | in        | tuser: operation; tdata: write_address, entry_value, low_bound,
//          |           |        high_bound, key
//  m_      | out       | tdata: found, position
//
// A write item goes into the table as it is accepted, if its address lies within the
// table. A search item alternates a probe step, which reads the table at the midpoint
// of the range, and a compare step on the registered read data, until the key is found
// or the range runs empty, and then ends in a done step.
// Reset clears the sequencer and the output valid; the table keeps no reset.
// A result waiting on m_tready holds the search in its final step only; the next
// item is taken once the result sits in the output register.
module sorted_table_binary_search_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // write_address[9:0], entry_value[41:10], low_bound[51:42], high_bound[62:52],
    // key[94:63], zero[95]
    input  logic [sts_pkg::S_DATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], position[10:1], zero[15:11]
    output logic [sts_pkg::M_DATA_W-1:0]  m_tdata
);
    import sts_pkg::*;

    wr_req_t             wr_req;
    rd_req_t             rd_req;
    logic [VALUE_W-1:0]  rd_data;
    logic                m_found;
    logic [INDEX_W-1:0]  m_position;

    sts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_op            (s_tuser),
        .s_write_address (s_tdata[9:0]),
        .s_entry_value   (s_tdata[41:10]),
        .s_low_bound     (s_tdata[51:42]),
        .s_high_bound    (s_tdata[62:52]),
        .s_key           (s_tdata[94:63]),
        .wr_req          (wr_req),
        .rd_req          (rd_req),
        .rd_data         (rd_data),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_found         (m_found),
        .m_position      (m_position)
    );

    sts_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_req  (wr_req),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    assign m_tdata = {{(M_DATA_W-INDEX_W-1){1'b0}}, m_position, m_found};

endmodule
